// ===== src/sdh_pkg.sv =====
// ----------------------------------------------------------------------------
// SD host sequencer package
// Shared types, codes and timing constants of the SD host sequencer.
// ----------------------------------------------------------------------------
package sdh_pkg;

    localparam logic [31:0] BLOCK_BYTES  = 32'd512;
    localparam logic [31:0] INIT_TIMEOUT = 32'd2000000;
    localparam logic [31:0] CMD_TIMEOUT  = 32'd100000;
    localparam logic [31:0] DATA_TIMEOUT = 32'd1000000;
    localparam logic [31:0] POWER_DELAY  = 32'd2000;
    localparam logic [31:0] RETRY_DELAY  = 32'd1000;
    localparam logic [22:0] MAX_BLOCKS   = 23'h7fffff;

    localparam int IN_BITS  = 296;
    localparam int OUT_BITS = 112;

    typedef enum logic [5:0] {
        PH_DETECT      = 6'd0,
        PH_POWER_UP    = 6'd1,
        PH_RESET       = 6'd2,
        PH_IFCOND      = 6'd3,
        PH_APP_INIT    = 6'd4,
        PH_OPCOND      = 6'd5,
        PH_OCR         = 6'd6,
        PH_CID         = 6'd7,
        PH_RCA         = 6'd8,
        PH_CSD         = 6'd9,
        PH_CSD_DATA    = 6'd10,
        PH_SELECT      = 6'd11,
        PH_SELECT_WAIT = 6'd12,
        PH_BLKLEN      = 6'd13,
        PH_APP_BUS     = 6'd14,
        PH_BUSW        = 6'd15,
        PH_CONFIG      = 6'd16,
        PH_READY       = 6'd17,
        PH_RD_CMD      = 6'd18,
        PH_RD_DATA     = 6'd19,
        PH_RD_STOP     = 6'd20,
        PH_RD_WAIT     = 6'd21,
        PH_RD_DONE     = 6'd22,
        PH_WR_APP      = 6'd23,
        PH_WR_ERASE    = 6'd24,
        PH_WR_CMD      = 6'd25,
        PH_WR_READY    = 6'd26,
        PH_WR_DATA     = 6'd27,
        PH_WR_BUSY     = 6'd28,
        PH_WR_DONE     = 6'd29,
        PH_WR_FIN      = 6'd30,
        PH_WR_FINISHED = 6'd31,
        PH_FAILED      = 6'd32
    } t_phase;

    localparam logic [2:0] ACT_POLL     = 3'd0;
    localparam logic [2:0] ACT_READ     = 3'd1;
    localparam logic [2:0] ACT_WSTART   = 3'd2;
    localparam logic [2:0] ACT_WCONT    = 3'd3;
    localparam logic [2:0] ACT_WFINISH  = 3'd4;
    localparam logic [2:0] ACT_WSINGLE  = 3'd5;
    localparam logic [2:0] ACT_INIT     = 3'd6;

    localparam logic [2:0] XR_WAIT    = 3'd0;
    localparam logic [2:0] XR_DONE    = 3'd1;
    localparam logic [2:0] XR_ERROR   = 3'd2;
    localparam logic [2:0] XR_TIMEOUT = 3'd3;
    localparam logic [2:0] XR_UNSUP   = 3'd4;

    localparam logic [1:0] ST_WAIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] CK_NONE   = 3'd0;
    localparam logic [2:0] CK_INIT   = 3'd1;
    localparam logic [2:0] CK_CMD    = 3'd2;
    localparam logic [2:0] CK_DATA   = 3'd3;
    localparam logic [2:0] CK_BUSY   = 3'd4;
    localparam logic [2:0] CK_CONFIG = 3'd5;

    localparam logic [2:0] RK_NONE = 3'd0;
    localparam logic [2:0] RK_R1   = 3'd1;
    localparam logic [2:0] RK_R2   = 3'd2;
    localparam logic [2:0] RK_R3   = 3'd3;
    localparam logic [2:0] RK_R6   = 3'd4;
    localparam logic [2:0] RK_R7   = 3'd5;

    localparam logic [1:0] PK_NONE  = 2'd0;
    localparam logic [1:0] PK_READ  = 2'd1;
    localparam logic [1:0] PK_CSD   = 2'd2;
    localparam logic [1:0] PK_WRITE = 2'd3;

    localparam logic [1:0] CFG_PRESENT = 2'd0;
    localparam logic [1:0] CFG_SPI     = 2'd1;
    localparam logic [1:0] CFG_DET_EN  = 2'd2;
    localparam logic [1:0] CFG_DET_INV = 2'd3;

    typedef struct packed {
        logic present;
        logic spi;
        logic det_en;
        logic det_inv;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_us;
        logic        detect_level;
        logic [31:0] start_page;
        logic [31:0] page_count;
        logic        buffer_valid;
        logic [2:0]  xfer_result;
        logic [31:0] resp_status;
        logic [31:0] resp_word0;
        logic [63:0] csd_hi;
        logic [63:0] csd_lo;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        reply;
        logic [2:0]  call_kind;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [2:0]  resp_kind;
        logic [1:0]  prepare_kind;
        logic [31:0] buffer_offset;
        logic        abort_out;
        logic        stop_write_out;
        logic [22:0] block_count;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [22:0] cap;
        logic [15:0] card_addr;
        logic        v2;
        logic        hc;
        logic [31:0] init_time;
        logic [31:0] phase_time;
        logic [31:0] retry_time;
        logic        in_flight;
        logic [31:0] cmd_time;
        logic [31:0] cur_block;
        logic [31:0] blocks_left;
        logic        any_written;
        logic [31:0] buf_done;
    } t_state;

    typedef struct packed {
        logic [22:0] blocks;
        logic        ver1;
    } t_csd;

endpackage

// ===== src/sdh_csd.sv =====
// ----------------------------------------------------------------------------
// SD host CSD decoder
// Derives the card capacity in blocks from the CSD register, saturated.
// ----------------------------------------------------------------------------
module sdh_csd (
    input  logic [63:0]   i_csd_hi,
    input  logic [63:0]   i_csd_lo,
    output sdh_pkg::t_csd o_csd
);
    import sdh_pkg::*;

    logic [7:0]  b0, b5, b6, b7, b8, b9, b10;
    logic [22:0] v1_size;
    logic [11:0] v0_size;
    logic [2:0]  v0_mult;
    logic [3:0]  v0_bl;
    logic [3:0]  v0_shift;
    logic [23:0] v0_blocks;

    assign b0  = i_csd_hi[63:56];
    assign b5  = i_csd_hi[23:16];
    assign b6  = i_csd_hi[15:8];
    assign b7  = i_csd_hi[7:0];
    assign b8  = i_csd_lo[63:56];
    assign b9  = i_csd_lo[55:48];
    assign b10 = i_csd_lo[47:40];

    assign v1_size   = {1'b0, b7[5:0], b8, b9} + 23'd1;
    assign v0_size   = {b6[1:0], b7, b8[7:6]};
    assign v0_mult   = {b9[1:0], b10[7]};
    assign v0_bl     = b5[3:0];
    assign v0_shift  = 4'(v0_mult) + v0_bl - 4'd7;
    assign v0_blocks = ({11'd0, {1'b0, v0_size} + 13'd1}) << v0_shift;

    always_comb begin
        o_csd.ver1   = (b0[7:6] == 2'd1);
        o_csd.blocks = '0;
        unique case (b0[7:6])
            2'd1: begin
                o_csd.blocks = (v1_size[22:13] != '0) ? MAX_BLOCKS : {v1_size[12:0], 10'd0};
            end
            2'd0: begin
                if (v0_bl >= 4'd9 && v0_bl <= 4'd11) begin
                    o_csd.blocks = v0_blocks[23] ? MAX_BLOCKS : v0_blocks[22:0];
                end
            end
            default: o_csd.blocks = '0;
        endcase
    end

endmodule

// ===== src/sdh_step.sv =====
// ----------------------------------------------------------------------------
// SD host sequencer step logic
// Computes the next sequencer state and the result of one registered beat.
// ----------------------------------------------------------------------------
module sdh_step (
    input  sdh_pkg::t_state  i_state,
    input  sdh_pkg::t_item   i_item,
    input  sdh_pkg::t_cfg    i_cfg,
    input  sdh_pkg::t_csd    i_csd,
    output sdh_pkg::t_state  o_state,
    output sdh_pkg::t_result o_result
);
    import sdh_pkg::*;

    function automatic void f_go(inout t_state s, input t_phase p, input logic [31:0] now);
        s.phase      = p;
        s.phase_time = now;
    endfunction

    function automatic void f_fail(inout t_state s, inout t_result r);
        s.phase     = PH_FAILED;
        r.abort_out = 1'b1;
    endfunction

    function automatic logic f_idle(input t_phase p);
        return p == PH_READY || p == PH_RD_DONE || p == PH_WR_READY ||
               p == PH_WR_DONE || p == PH_WR_FINISHED;
    endfunction

    function automatic void f_decode(inout t_state s, inout t_result r, input t_csd c,
                                     input logic spi, input logic [31:0] now);
        s.cap = c.blocks;
        if (c.blocks == '0 || s.hc != c.ver1) begin
            f_fail(s, r);
        end else begin
            f_go(s, spi ? PH_BLKLEN : PH_SELECT, now);
        end
    endfunction

    function automatic logic f_read(inout t_state s, inout t_result r, input logic [31:0] page,
                                    input logic [31:0] count, input logic bufok,
                                    input logic [31:0] now);
        logic rep;
        rep = 1'b0;
        if (s.phase == PH_RD_DONE) begin
            f_go(s, PH_READY, now);
            rep = 1'b1;
        end else if (s.phase == PH_READY) begin
            if (!bufok || count == '0 || page >= {9'd0, s.cap} ||
                count > {9'd0, s.cap} - page) begin
                f_fail(s, r);
            end else begin
                s.cur_block      = page;
                s.blocks_left    = count;
                s.any_written    = 1'b0;
                s.buf_done       = '0;
                r.prepare_kind   = PK_READ;
                r.buffer_offset  = '0;
                f_go(s, PH_RD_CMD, now);
            end
        end
        return rep;
    endfunction

    function automatic logic f_wstart(inout t_state s, inout t_result r, input logic [31:0] page,
                                      input logic [31:0] count, input logic spi,
                                      input logic [31:0] now);
        logic rep;
        rep = 1'b0;
        if (s.phase == PH_WR_READY) begin
            rep = 1'b1;
        end else if (s.phase == PH_READY) begin
            if (count == '0 || page >= {9'd0, s.cap}) begin
                f_fail(s, r);
            end else begin
                s.cur_block   = page;
                s.blocks_left = count;
                s.any_written = 1'b0;
                s.buf_done    = '0;
                f_go(s, spi ? PH_WR_APP : PH_WR_READY, now);
            end
        end
        return rep;
    endfunction

    function automatic logic f_wcont(inout t_state s, inout t_result r, input logic bufok,
                                     input logic spi, input logic [31:0] now);
        logic rep;
        rep = 1'b0;
        if (s.phase == PH_WR_DONE) begin
            f_go(s, PH_WR_READY, now);
            rep = 1'b1;
        end else if (s.phase == PH_WR_READY) begin
            if (!bufok || s.cur_block >= {9'd0, s.cap}) begin
                f_fail(s, r);
            end else begin
                r.prepare_kind  = PK_WRITE;
                r.buffer_offset = '0;
                f_go(s, spi ? PH_WR_DATA : PH_WR_CMD, now);
            end
        end
        return rep;
    endfunction

    function automatic logic f_wfinish(inout t_state s, inout t_result r, input logic spi,
                                       input logic [31:0] now);
        logic rep;
        rep = 1'b0;
        if (s.phase == PH_WR_FINISHED) begin
            f_go(s, PH_READY, now);
            rep = 1'b1;
        end else if (s.phase == PH_WR_READY || s.phase == PH_WR_DONE) begin
            if (spi) begin
                r.stop_write_out = 1'b1;
            end
            f_go(s, PH_WR_FIN, now);
        end
        return rep;
    endfunction

    t_state      s;
    t_result     r;
    t_phase      ph;
    logic        spi;
    logic [31:0] now;
    logic [31:0] rca;
    logic [31:0] baddr;
    logic [2:0]  xr;
    logic [2:0]  rr;
    logic [31:0] ft;
    logic        c_cmd, c_raw, c_app, c_busy, c_poll, spi_bad, ok, rep, skip;
    logic [5:0]  c_idx;
    logic [31:0] c_arg;
    logic [2:0]  c_rk;
    logic [2:0]  c_pkind;

    assign spi   = i_cfg.spi;
    assign now   = i_item.now_us;
    assign ph    = i_state.phase;
    assign rca   = {i_state.card_addr, 16'd0};
    assign baddr = i_state.hc ? i_state.cur_block : {i_state.cur_block[22:0], 9'd0};
    assign xr    = (i_item.xfer_result > XR_UNSUP) ? XR_ERROR : i_item.xfer_result;

    always_comb begin
        s       = i_state;
        r       = '0;
        rep     = 1'b0;
        skip    = 1'b0;
        c_cmd   = 1'b0;
        c_raw   = 1'b0;
        c_app   = 1'b0;
        c_busy  = 1'b0;
        c_poll  = 1'b0;
        c_idx   = '0;
        c_arg   = '0;
        c_rk    = RK_NONE;
        c_pkind = CK_NONE;
        rr      = XR_WAIT;
        ft      = '0;
        spi_bad = 1'b0;
        ok      = 1'b0;

        if (i_item.action == ACT_POLL) begin
            if (ph == PH_FAILED) begin
                r.status = ST_ERROR;
            end else if (i_cfg.det_en && i_item.detect_level == i_cfg.det_inv) begin
                if (ph != PH_DETECT) begin
                    f_fail(s, r);
                    r.status = ST_ERROR;
                end
            end else if (ph == PH_DETECT) begin
                r.call_kind = CK_INIT;
                if (i_item.xfer_result != XR_DONE) begin
                    f_fail(s, r);
                    r.status = ST_ERROR;
                end else begin
                    s.init_time  = now;
                    s.retry_time = now;
                    f_go(s, PH_POWER_UP, now);
                end
            end else if (ph < PH_READY && (now - i_state.init_time) > INIT_TIMEOUT) begin
                f_fail(s, r);
                r.status = ST_ERROR;
            end else if (f_idle(ph)) begin
                r.status = ST_IDLE;
            end else if (ph > PH_READY && (now - i_state.phase_time) > DATA_TIMEOUT) begin
                f_fail(s, r);
                r.status = ST_ERROR;
            end else begin
                unique case (ph)
                    PH_RESET:    begin c_cmd = 1'b1; c_rk = RK_NONE; end
                    PH_IFCOND: begin
                        c_cmd = 1'b1; c_raw = 1'b1; c_idx = 6'd8;
                        c_arg = 32'h1aa; c_rk = RK_R7;
                    end
                    PH_APP_INIT, PH_APP_BUS, PH_WR_APP: begin
                        if (ph != PH_APP_INIT || (now - i_state.retry_time) < 32'h80000000) begin
                            c_cmd = 1'b1; c_app = 1'b1; c_idx = 6'd55;
                            c_arg = rca; c_rk = RK_R1;
                        end
                    end
                    PH_OPCOND: begin
                        c_cmd = 1'b1; c_idx = 6'd41;
                        c_arg = (spi ? 32'h0 : 32'h00ff8000) |
                                (i_state.v2 ? 32'h40000000 : 32'h0);
                        c_rk  = spi ? RK_R1 : RK_R3;
                    end
                    PH_OCR:      begin c_cmd = 1'b1; c_idx = 6'd58; c_rk = RK_R3; end
                    PH_CID:      begin c_cmd = 1'b1; c_idx = 6'd2;  c_rk = RK_R2; end
                    PH_RCA:      begin c_cmd = 1'b1; c_idx = 6'd3;  c_rk = RK_R6; end
                    PH_CSD: begin
                        c_cmd = 1'b1; c_idx = 6'd9; c_arg = rca;
                        c_rk  = spi ? RK_R1 : RK_R2;
                    end
                    PH_SELECT: begin
                        c_cmd = 1'b1; c_idx = 6'd7; c_arg = rca; c_rk = RK_R1;
                    end
                    PH_BLKLEN: begin
                        if (!i_state.hc) begin
                            c_cmd = 1'b1; c_idx = 6'd16; c_arg = BLOCK_BYTES; c_rk = RK_R1;
                        end
                    end
                    PH_BUSW: begin
                        c_cmd = 1'b1; c_idx = 6'd6; c_arg = 32'd2; c_rk = RK_R1;
                    end
                    PH_RD_CMD: begin
                        c_cmd = 1'b1; c_idx = spi ? 6'd18 : 6'd17; c_arg = baddr; c_rk = RK_R1;
                    end
                    PH_RD_STOP:  begin c_cmd = 1'b1; c_idx = 6'd12; c_rk = RK_R1; end
                    PH_WR_ERASE: begin
                        c_cmd = 1'b1; c_idx = 6'd23; c_arg = i_state.blocks_left; c_rk = RK_R1;
                    end
                    PH_WR_CMD: begin
                        c_cmd = 1'b1; c_idx = spi ? 6'd25 : 6'd24; c_arg = baddr; c_rk = RK_R1;
                    end
                    PH_CSD_DATA, PH_RD_DATA, PH_WR_DATA: begin
                        c_poll = 1'b1; c_pkind = CK_DATA;
                    end
                    PH_SELECT_WAIT, PH_RD_WAIT, PH_WR_BUSY, PH_WR_FIN: begin
                        if (spi) begin
                            c_poll = 1'b1; c_pkind = CK_BUSY;
                        end else begin
                            c_cmd = 1'b1; c_busy = 1'b1; c_idx = 6'd13;
                            c_arg = rca; c_rk = RK_R1;
                        end
                    end
                    default: skip = 1'b1;
                endcase

                if (c_cmd) begin
                    r.call_kind = CK_CMD;
                    r.cmd_index = c_idx;
                    r.cmd_arg   = c_arg;
                    r.resp_kind = c_rk;
                    ft = i_state.in_flight ? i_state.cmd_time : now;
                    rr = xr;
                    if (rr == XR_WAIT && (now - ft) > CMD_TIMEOUT) begin
                        rr = XR_ERROR;
                    end
                    s.cmd_time  = ft;
                    s.in_flight = (rr == XR_WAIT);
                    if (!c_raw) begin
                        if (rr != XR_WAIT && rr != XR_DONE) begin
                            f_fail(s, r);
                        end
                        spi_bad = rr == XR_DONE && spi && i_item.resp_status != '0 &&
                                  ph != PH_RESET && ph != PH_APP_INIT && ph != PH_OPCOND;
                        if (spi_bad) begin
                            f_fail(s, r);
                        end
                        ok = (rr == XR_DONE) && !spi_bad;
                        if (c_app && ok && !spi && !i_item.resp_status[5]) begin
                            f_fail(s, r);
                            ok = 1'b0;
                        end
                        if (c_busy) begin
                            ok = ok && (i_item.resp_status[12:8] == 5'h09);
                        end
                    end
                end else if (c_poll) begin
                    r.call_kind = c_pkind;
                    if (xr != XR_WAIT && xr != XR_DONE) begin
                        f_fail(s, r);
                    end
                    ok = (xr == XR_DONE);
                end

                unique case (ph)
                    PH_POWER_UP: begin
                        if ((now - i_state.init_time) >= POWER_DELAY) f_go(s, PH_RESET, now);
                    end
                    PH_RESET: begin
                        if (ok) begin
                            if (spi && i_item.resp_status != 32'd1) f_fail(s, r);
                            else f_go(s, PH_IFCOND, now);
                        end
                    end
                    PH_IFCOND: begin
                        if ((!spi && rr == XR_TIMEOUT) || (spi && rr == XR_UNSUP)) begin
                            f_go(s, PH_APP_INIT, now);
                        end else if (rr == XR_DONE && i_item.resp_word0 == 32'h1aa) begin
                            s.v2 = 1'b1;
                            f_go(s, PH_APP_INIT, now);
                        end else if (rr != XR_WAIT) begin
                            f_fail(s, r);
                        end
                    end
                    PH_APP_INIT: if (ok) f_go(s, PH_OPCOND, now);
                    PH_OPCOND: begin
                        if (ok) begin
                            if (spi ? (i_item.resp_status == '0) : i_item.resp_word0[31]) begin
                                s.hc = i_state.v2 && i_item.resp_word0[30];
                                f_go(s, spi ? PH_OCR : PH_CID, now);
                            end else begin
                                s.retry_time = now + RETRY_DELAY;
                                f_go(s, PH_APP_INIT, now);
                            end
                        end
                    end
                    PH_OCR: begin
                        if (ok) begin
                            s.hc = i_state.v2 && i_item.resp_word0[30];
                            f_go(s, PH_CSD, now);
                        end
                    end
                    PH_CID: if (ok) f_go(s, PH_RCA, now);
                    PH_RCA: begin
                        if (ok) begin
                            s.card_addr = i_item.resp_word0[31:16];
                            if (i_item.resp_word0[31:16] != '0) f_go(s, PH_CSD, now);
                            else f_fail(s, r);
                        end
                    end
                    PH_CSD: begin
                        if (ok) begin
                            if (spi) begin
                                r.prepare_kind = PK_CSD;
                                f_go(s, PH_CSD_DATA, now);
                            end else begin
                                f_decode(s, r, i_csd, spi, now);
                            end
                        end
                    end
                    PH_CSD_DATA:    if (ok) f_decode(s, r, i_csd, spi, now);
                    PH_SELECT:      if (ok) f_go(s, PH_SELECT_WAIT, now);
                    PH_SELECT_WAIT: if (ok) f_go(s, PH_BLKLEN, now);
                    PH_BLKLEN: begin
                        if (i_state.hc || ok) f_go(s, spi ? PH_CONFIG : PH_APP_BUS, now);
                    end
                    PH_APP_BUS: if (ok) f_go(s, PH_BUSW, now);
                    PH_BUSW:    if (ok) f_go(s, PH_CONFIG, now);
                    PH_CONFIG: begin
                        r.call_kind = CK_CONFIG;
                        f_go(s, PH_READY, now);
                    end
                    PH_RD_CMD: if (ok) f_go(s, PH_RD_DATA, now);
                    PH_RD_DATA: begin
                        if (ok) begin
                            s.cur_block   = i_state.cur_block + 32'd1;
                            s.buf_done    = i_state.buf_done + 32'd1;
                            s.blocks_left = i_state.blocks_left - 32'd1;
                            if (!spi) begin
                                f_go(s, PH_RD_WAIT, now);
                            end else if (s.blocks_left == '0) begin
                                f_go(s, PH_RD_STOP, now);
                            end else begin
                                r.prepare_kind  = PK_READ;
                                r.buffer_offset = s.buf_done;
                                f_go(s, PH_RD_DATA, now);
                            end
                        end
                    end
                    PH_RD_STOP: if (ok) f_go(s, PH_RD_WAIT, now);
                    PH_RD_WAIT: begin
                        if (ok) begin
                            if (i_state.blocks_left != '0) begin
                                r.prepare_kind  = PK_READ;
                                r.buffer_offset = i_state.buf_done;
                                f_go(s, PH_RD_CMD, now);
                            end else begin
                                f_go(s, PH_RD_DONE, now);
                            end
                        end
                    end
                    PH_WR_APP:   if (ok) f_go(s, PH_WR_ERASE, now);
                    PH_WR_ERASE: if (ok) f_go(s, PH_WR_CMD, now);
                    PH_WR_CMD:   if (ok) f_go(s, spi ? PH_WR_READY : PH_WR_DATA, now);
                    PH_WR_DATA:  if (ok) f_go(s, PH_WR_BUSY, now);
                    PH_WR_BUSY: begin
                        if (ok) begin
                            s.cur_block   = i_state.cur_block + 32'd1;
                            s.any_written = 1'b1;
                            f_go(s, PH_WR_DONE, now);
                        end
                    end
                    PH_WR_FIN: if (ok) f_go(s, PH_WR_FINISHED, now);
                    default: skip = 1'b0;
                endcase
                r.status = (s.phase == PH_FAILED) ? ST_ERROR : ST_WAIT;
            end
        end else begin
            priority case (i_item.action)
                ACT_READ: rep = f_read(s, r, i_item.start_page, i_item.page_count,
                                       i_item.buffer_valid, now);
                ACT_WSTART: rep = f_wstart(s, r, i_item.start_page, i_item.page_count,
                                           spi, now);
                ACT_WCONT:   rep = f_wcont(s, r, i_item.buffer_valid, spi, now);
                ACT_WFINISH: rep = f_wfinish(s, r, spi, now);
                ACT_WSINGLE: begin
                    if (s.phase == PH_READY) begin
                        void'(f_wstart(s, r, i_item.start_page, 32'd1, spi, now));
                    end
                    if (s.phase == PH_WR_DONE) begin
                        void'(f_wcont(s, r, i_item.buffer_valid, spi, now));
                    end
                    if (s.phase == PH_WR_FINISHED) begin
                        rep = f_wfinish(s, r, spi, now);
                    end else if (s.phase == PH_WR_READY) begin
                        if (!s.any_written) void'(f_wcont(s, r, i_item.buffer_valid, spi, now));
                        else void'(f_wfinish(s, r, spi, now));
                    end
                end
                ACT_INIT: begin
                    s       = '0;
                    s.phase = PH_FAILED;
                    if (i_cfg.present) f_go(s, PH_DETECT, now);
                end
                default: skip = 1'b1;
            endcase
            r.status = (s.phase == PH_FAILED) ? ST_ERROR : (f_idle(s.phase) ? ST_IDLE : ST_WAIT);
        end

        r.reply       = rep;
        r.block_count = s.cap;
        o_state       = s;
        o_result      = r;
    end

endmodule

// ===== src/sd_card_host_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// SD card host sequencer
// Steps the SD card bring-up and block transfer sequence, one beat per item.
// ----------------------------------------------------------------------------
// Each input beat (a poll, a transfer request or init) is captured in an input
// register, the sequencer state and the result are computed in one pass of
// logic, and the result is held in an output register. A beat can be accepted
// every clock cycle, and the input side only stalls when the output register
// is full and not being taken.
module sd_card_host_sequencer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic         i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now_us, detect_level, start_page, page_count, buffer_valid, xfer_result,
    // resp_status, resp_word0, csd_hi, csd_lo, zero pad
    input  logic [295:0] i_s_axis_tdata,
    // action
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status, reply, call_kind, cmd_index, cmd_arg, resp_kind, prepare_kind,
    // buffer_offset, abort_out, stop_write_out, block_count, zero pad
    output logic [111:0] o_m_axis_tdata
);
    import sdh_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_item   n_item;
    logic    r_in_valid;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    t_csd    csd;
    logic    adv;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_comb begin
        n_item.action       = i_s_axis_tuser;
        n_item.now_us       = i_s_axis_tdata[31:0];
        n_item.detect_level = i_s_axis_tdata[32];
        n_item.start_page   = i_s_axis_tdata[64:33];
        n_item.page_count   = i_s_axis_tdata[96:65];
        n_item.buffer_valid = i_s_axis_tdata[97];
        n_item.xfer_result  = i_s_axis_tdata[100:98];
        n_item.resp_status  = i_s_axis_tdata[132:101];
        n_item.resp_word0   = i_s_axis_tdata[164:133];
        n_item.csd_hi       = i_s_axis_tdata[228:165];
        n_item.csd_lo       = i_s_axis_tdata[292:229];
    end

    sdh_csd u_csd (
        .i_csd_hi (r_item.csd_hi),
        .i_csd_lo (r_item.csd_lo),
        .o_csd    (csd)
    );

    sdh_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_csd    (csd),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '{present: 1'b0, spi: 1'b1, det_en: 1'b0, det_inv: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESENT: r_cfg.present <= i_cfg_wdata;
                CFG_SPI:     r_cfg.spi     <= i_cfg_wdata;
                CFG_DET_EN:  r_cfg.det_en  <= i_cfg_wdata;
                CFG_DET_INV: r_cfg.det_inv <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_state.phase <= PH_FAILED;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item <= n_item;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.block_count, r_out.stop_write_out, r_out.abort_out,
                              r_out.buffer_offset, r_out.prepare_kind, r_out.resp_kind,
                              r_out.cmd_arg, r_out.cmd_index, r_out.call_kind, r_out.reply,
                              r_out.status};

endmodule

// ===== src/sdh_checker.sv =====
// ----------------------------------------------------------------------------
// SD host sequencer port checker
// Checks result beats seen on the top-level ports over time.
// ----------------------------------------------------------------------------
module sdh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic [111:0] o_m_axis_tdata
);
    import sdh_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat present right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    a_cmd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[5:3] != CK_CMD |->
            o_m_axis_tdata[11:6] == '0 && o_m_axis_tdata[43:12] == '0 &&
            o_m_axis_tdata[46:44] == RK_NONE)
        else $error("command fields set without a command call");

    a_abort_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[81] |-> o_m_axis_tdata[1:0] == ST_ERROR)
        else $error("abort without error status");

    a_reply_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> o_m_axis_tdata[1:0] == ST_IDLE)
        else $error("completed request not reported idle");

endmodule

bind sd_card_host_sequencer_top sdh_checker u_sdh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
